// ----- rtl/core/text_cell_attribute_renderer_macros.svh -----
// Assertion macros shared by the text cell renderer RTL.
`ifndef TEXT_CELL_ATTRIBUTE_RENDERER_MACROS_SVH
`define TEXT_CELL_ATTRIBUTE_RENDERER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCAR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcar assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define TCAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcar assertion failed (next cycle)");

`endif

// ----- rtl/core/tcar_pkg.sv -----
// Shared constants for the text cell renderer.
package tcar_pkg;

   // Font store geometry
   localparam int FONT_BYTES_DEFAULT = 32768;
   localparam int FONT_ADDR_W        = 15;
   localparam int FONT_DATA_W        = 8;

   // Payload widths
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int SCAN_W    = 4;
   localparam int GLYPH_W   = 11;
   localparam int PIXELS_W  = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   // Command codes
   localparam logic CMD_RENDER = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR_MAP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_START = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_END   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_OFF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_MODE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_ENABLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_OPTIONS = 3'd6;

   // Register reset values
   localparam logic [3:0] ATTR_MAP_RESET     = 4'd4;
   localparam logic [3:0] CURSOR_START_RESET = 4'd6;
   localparam logic [3:0] CURSOR_END_RESET   = 4'd7;
   localparam logic       CURSOR_OFF_RESET   = 1'b0;
   localparam logic       BLINK_MODE_RESET   = 1'b0;
   localparam logic       VIDEO_ENABLE_RESET = 1'b1;
   localparam logic [2:0] FONT_OPTIONS_RESET = 3'd7;

   // Attribute codes with fixed meaning
   localparam logic [ATTR_W-1:0] ATTR_LO_FIRST    = 8'h01;
   localparam logic [ATTR_W-1:0] ATTR_LO_LAST     = 8'h0E;
   localparam logic [ATTR_W-1:0] ATTR_NORMAL      = 8'h07;
   localparam logic [ATTR_W-1:0] ATTR_NORMAL_BOLD = 8'h0F;
   localparam logic [ATTR_W-1:0] ATTR_HI_FIRST    = 8'h11;
   localparam logic [ATTR_W-1:0] ATTR_BLINK_FIRST = 8'h81;
   localparam logic [ATTR_W-1:0] ATTR_BLINK_LAST  = 8'h8E;
   localparam logic [ATTR_W-1:0] ATTR_BLINK_NORM  = 8'h87;
   localparam logic [ATTR_W-1:0] ATTR_BLINK_BOLD  = 8'h8F;

endpackage

// ----- rtl/core/tcar_ram.sv -----
// Generic simple dual-port RAM with registered, enabled read.
module tcar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, hold data while disabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/text_cell_attribute_renderer.sv -----
// Text cell renderer: one 8-pixel slice of a character scanline per transfer.
//
// Takes one transfer per clock on req_ and gives one rsp_ transfer for each
// render command, via the read stage and response register; a load command
// writes one byte of the font store and gives no response. The font store is
// a single synchronous RAM of FONT_BYTES bytes (a power of two, up to 32768);
// the rate is set by its one read and one write port, so one command per
// cycle is sustained. A render reads the RAM in the cycle it is taken, then
// the pixel slice is composed into the response register. req_ready drops
// only while a finished response waits and the render behind it is also done.
// Font bytes never loaded read back as unknown. Configuration writes on csr_
// are always taken and must be made while no render is in flight.
`include "text_cell_attribute_renderer_macros.svh"

module text_cell_attribute_renderer #(
   parameter int FONT_BYTES = tcar_pkg::FONT_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Command channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [tcar_pkg::FONT_ADDR_W-1:0] req_font_address,
   input  logic [tcar_pkg::FONT_DATA_W-1:0] req_font_byte,
   input  logic [tcar_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcar_pkg::ATTR_W-1:0]      req_attribute,
   input  logic [tcar_pkg::SCAN_W-1:0]      req_scanline,
   input  logic                             req_at_cursor,
   input  logic                             req_blink_phase,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tcar_pkg::PIXELS_W-1:0]    rsp_pixels,
   output logic [tcar_pkg::GLYPH_W-1:0]     rsp_glyph_index,
   // Register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcar_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcar_pkg::CSR_DATA_W-1:0]  csr_data
);

   import tcar_pkg::*;

   localparam int ADDR_W = $clog2(FONT_BYTES);

   // Configuration registers
   logic [3:0] attr_map_ff,     attr_map_in;
   logic [3:0] cursor_start_ff, cursor_start_in;
   logic [3:0] cursor_end_ff,   cursor_end_in;
   logic       cursor_off_ff,   cursor_off_in;
   logic       blink_mode_ff,   blink_mode_in;
   logic       video_enable_ff, video_enable_in;
   logic [2:0] font_options_ff, font_options_in;

   // Read stage
   logic                s1_valid_ff,  s1_valid_in;
   logic                s1_c0_ff,     s1_c0_in;
   logic                s1_c1_ff,     s1_c1_in;
   logic                s1_cursor_ff, s1_cursor_in;
   logic [GLYPH_W-1:0]  s1_glyph_ff,  s1_glyph_in;

   // Response stage
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [PIXELS_W-1:0] rsp_pixels_ff, rsp_pixels_in;
   logic [GLYPH_W-1:0]  rsp_glyph_ff,  rsp_glyph_in;

   logic req_fire;
   logic render_fire;
   logic load_fire;
   logic s1_adv;
   logic csr_fire;

   logic [ATTR_W-1:0]  a;
   logic [6:0]         lo;
   logic               blk;
   logic               inv_hi;
   logic               inv_lo;
   logic               c0;
   logic               c1;
   logic               bold;
   logic               cline;
   logic               cursor;
   logic               blinking;
   logic               bank;
   logic [FONT_ADDR_W-1:0] rd_full;
   logic [FONT_DATA_W-1:0] row;
   logic [PIXELS_W-1:0]    m0;
   logic [PIXELS_W-1:0]    m1;

   // Handshakes
   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign req_fire    = req_valid && req_ready;
   assign render_fire = req_fire && (req_command == CMD_RENDER);
   assign load_fire   = req_fire && (req_command == CMD_LOAD);
   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;

   // Decode register writes
   always_comb begin
      attr_map_in     = attr_map_ff;
      cursor_start_in = cursor_start_ff;
      cursor_end_in   = cursor_end_ff;
      cursor_off_in   = cursor_off_ff;
      blink_mode_in   = blink_mode_ff;
      video_enable_in = video_enable_ff;
      font_options_in = font_options_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_ATTR_MAP:     attr_map_in     = csr_data[3:0];
            CSR_CURSOR_START: cursor_start_in = csr_data[3:0];
            CSR_CURSOR_END:   cursor_end_in   = csr_data[3:0];
            CSR_CURSOR_OFF:   cursor_off_in   = csr_data[0];
            CSR_BLINK_MODE:   blink_mode_in   = csr_data[0];
            CSR_VIDEO_ENABLE: video_enable_in = csr_data[0];
            CSR_FONT_OPTIONS: font_options_in = csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Classify the attribute into clear/set colours and bold class
   always_comb begin
      a      = req_attribute;
      lo     = a[6:0];
      blk    = blink_mode_ff;
      inv_hi = attr_map_ff[2];
      inv_lo = attr_map_ff[0];
      bold   = a[3];
      c0     = 1'b1;
      c1     = 1'b0;
      if (a >= ATTR_HI_FIRST && a[2:0] != 3'd0) begin
         c0 = inv_hi;
         c1 = !inv_hi;
         if (attr_map_ff[3]) begin
            bold = 1'b1;
         end
      end
      if (a >= ATTR_LO_FIRST && a <= ATTR_LO_LAST && a != ATTR_NORMAL) begin
         c0 = inv_lo;
         c1 = !inv_lo;
         if (attr_map_ff[1]) begin
            bold = 1'b1;
         end
      end
      if (blk && a >= ATTR_BLINK_FIRST && a <= ATTR_BLINK_LAST && a != ATTR_BLINK_NORM) begin
         c0 = inv_lo;
         c1 = !inv_lo;
      end
      if (a == ATTR_NORMAL || a == ATTR_NORMAL_BOLD ||
          (blk && (a == ATTR_BLINK_NORM || a == ATTR_BLINK_BOLD))) begin
         c0 = 1'b0;
         c1 = 1'b1;
      end
      if (a >= ATTR_BLINK_FIRST && a <= ATTR_BLINK_BOLD) begin
         if (!blk) begin
            c0 = 1'b0;
            c1 = 1'b1;
         end
         bold = a[3];
      end
      // Solid black: both nibbles equal (blink table: low seven bits only)
      if (!blk) begin
         if (a[7:4] == a[3:0]) begin
            c0 = 1'b0;
            c1 = 1'b0;
         end
      end else if (!lo[3] && lo[6:4] == lo[2:0]) begin
         c0 = 1'b0;
         c1 = 1'b0;
      end

      // Cursor rows and blink
      cline    = !cursor_off_ff && ({1'b0, cursor_start_ff, 1'b0} <= {2'b00, req_scanline})
                 && ({1'b0, cursor_end_ff, 1'b0} >= {2'b00, req_scanline});
      cursor   = req_at_cursor && cline && video_enable_ff && req_blink_phase;
      blinking = req_blink_phase && blk && a[7] && !cursor;
      if (blinking) begin
         c1 = c0;
      end

      // Glyph: font set, bold bank, character
      bank    = font_options_ff[2] ? bold : !bold;
      rd_full = {font_options_ff[1:0], bank, req_char_code, req_scanline};
   end

   // Read stage next values
   always_comb begin
      s1_valid_in  = render_fire || (s1_valid_ff && !s1_adv);
      s1_c0_in     = s1_c0_ff;
      s1_c1_in     = s1_c1_ff;
      s1_cursor_in = s1_cursor_ff;
      s1_glyph_in  = s1_glyph_ff;
      if (render_fire) begin
         s1_c0_in     = c0;
         s1_c1_in     = c1;
         s1_cursor_in = cursor;
         s1_glyph_in  = rd_full[FONT_ADDR_W-1 -: GLYPH_W];
      end
   end

   // Font store
   tcar_ram #(
      .WIDTH (FONT_DATA_W),
      .DEPTH (FONT_BYTES)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_font_address[ADDR_W-1:0]),
      .wr_data (req_font_byte),
      .rd_en   (render_fire),
      .rd_addr (rd_full[ADDR_W-1:0]),
      .rd_data (row)
   );

   // Compose pixels into the response register
   always_comb begin
      m0            = {PIXELS_W{s1_c0_ff}};
      m1            = {PIXELS_W{s1_c1_ff}};
      rsp_valid_in  = s1_adv || (rsp_valid_ff && !rsp_ready);
      rsp_pixels_in = rsp_pixels_ff;
      rsp_glyph_in  = rsp_glyph_ff;
      if (s1_adv) begin
         rsp_pixels_in = ((row & m1) | (~row & m0)) ^ {PIXELS_W{s1_cursor_ff}};
         rsp_glyph_in  = s1_glyph_ff;
      end
   end

   // Hold control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_map_ff     <= ATTR_MAP_RESET;
         cursor_start_ff <= CURSOR_START_RESET;
         cursor_end_ff   <= CURSOR_END_RESET;
         cursor_off_ff   <= CURSOR_OFF_RESET;
         blink_mode_ff   <= BLINK_MODE_RESET;
         video_enable_ff <= VIDEO_ENABLE_RESET;
         font_options_ff <= FONT_OPTIONS_RESET;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         attr_map_ff     <= attr_map_in;
         cursor_start_ff <= cursor_start_in;
         cursor_end_ff   <= cursor_end_in;
         cursor_off_ff   <= cursor_off_in;
         blink_mode_ff   <= blink_mode_in;
         video_enable_ff <= video_enable_in;
         font_options_ff <= font_options_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      s1_c0_ff      <= s1_c0_in;
      s1_c1_ff      <= s1_c1_in;
      s1_cursor_ff  <= s1_cursor_in;
      s1_glyph_ff   <= s1_glyph_in;
      rsp_pixels_ff <= rsp_pixels_in;
      rsp_glyph_ff  <= rsp_glyph_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixels      = rsp_pixels_ff;
   assign rsp_glyph_index = rsp_glyph_ff;

   // Checks
   `TCAR_ASSERT_NEXT(a_load_no_result, clock, reset, load_fire, !s1_valid_ff)
   `TCAR_ASSERT_NEXT(a_render_enters, clock, reset, render_fire, s1_valid_ff)
   `TCAR_ASSERT_NEXT(a_stall_holds, clock, reset, s1_valid_ff && !s1_adv,
                     $stable(s1_glyph_ff) && $stable(row))
   `TCAR_ASSERT_NOW(a_ready_only_full, clock, reset, !req_ready,
                    rsp_valid_ff && !rsp_ready && s1_valid_ff)

endmodule

// ----- tb/sv/tb_text_cell_attribute_renderer.sv -----
// Self-checking testbench for the text cell renderer: font loads, slices, register settings.
`timescale 1ns / 1ps

module tb_text_cell_attribute_renderer;
   import tcar_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RESET_CYCLES    = 10;
   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 84;
   localparam int LONG_HOLD       = 80;
   localparam int SETTLE_CYCLES   = 6;
   localparam int NUM_REGS        = 7;

   // Index past the register list; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   // Highest low-seven-bit value that the blink table still paints solid black
   localparam logic [ATTR_W-1:0] SOLID_LIMIT = 8'h77;

   typedef struct packed {
      logic                   command;
      logic [FONT_ADDR_W-1:0] font_address;
      logic [FONT_DATA_W-1:0] font_byte;
      logic [CHAR_W-1:0]      char_code;
      logic [ATTR_W-1:0]      attribute;
      logic [SCAN_W-1:0]      scanline;
      logic                   at_cursor;
      logic                   blink_phase;
   } cell_cmd_type;

   typedef struct packed {
      logic [PIXELS_W-1:0] pixels;
      logic [GLYPH_W-1:0]  glyph_index;
   } slice_type;

   // Tracks font contents and registers, predicts each rendered slice, checks responses.
   class slice_scoreboard;
      bit [FONT_DATA_W-1:0] font_rows [FONT_BYTES_DEFAULT];
      logic [3:0] attr_map;
      logic [3:0] cursor_start;
      logic [3:0] cursor_end;
      logic       cursor_off;
      logic       blink_mode;
      logic       video_enable;
      logic [2:0] font_options;
      slice_type  expected_slices [$];
      int         renders_seen;
      int         loads_seen;
      int         slices_checked;
      int         failures;

      function new();
         attr_map       = ATTR_MAP_RESET;
         cursor_start   = CURSOR_START_RESET;
         cursor_end     = CURSOR_END_RESET;
         cursor_off     = CURSOR_OFF_RESET;
         blink_mode     = BLINK_MODE_RESET;
         video_enable   = VIDEO_ENABLE_RESET;
         font_options   = FONT_OPTIONS_RESET;
         renders_seen   = 0;
         loads_seen     = 0;
         slices_checked = 0;
         failures       = 0;
      endfunction

      // Decide clear-pixel color c0, set-pixel color c1 and the bold class.
      function void classify_attr(input logic [ATTR_W-1:0] a, output bit c0, output bit c1,
                                  output bit bold);
         bit inv_lo;
         bit inv_hi;
         inv_lo = attr_map[0];
         inv_hi = attr_map[2];
         bold   = a[3];
         c0     = 1'b1;
         c1     = 1'b0;
         // Upper group, unless the foreground bits are clear
         if (a >= ATTR_HI_FIRST && a[2:0] != 3'd0) begin
            c0 = inv_hi;
            c1 = !inv_hi;
            if (attr_map[3]) bold = 1'b1;
         end
         // Lower group, except the plain normal attribute
         if (a >= ATTR_LO_FIRST && a <= ATTR_LO_LAST && a != ATTR_NORMAL) begin
            c0 = inv_lo;
            c1 = !inv_lo;
            if (attr_map[1]) bold = 1'b1;
         end
         // Blink table paints its low run like the lower group
         if (blink_mode && a >= ATTR_BLINK_FIRST && a <= ATTR_BLINK_LAST &&
             a != ATTR_BLINK_NORM) begin
            c0 = inv_lo;
            c1 = !inv_lo;
         end
         // Normal attributes are always amber on black
         if (a == ATTR_NORMAL || a == ATTR_NORMAL_BOLD ||
             (blink_mode && (a == ATTR_BLINK_NORM || a == ATTR_BLINK_BOLD))) begin
            c0 = 1'b0;
            c1 = 1'b1;
         end
         // Blink run keeps its own bold bit; without blink table it is plain normal
         if (a >= ATTR_BLINK_FIRST && a <= ATTR_BLINK_BOLD) begin
            if (!blink_mode) begin
               c0 = 1'b0;
               c1 = 1'b1;
            end
            bold = a[3];
         end
         // Repeated-nibble attributes are solid black
         if (!blink_mode) begin
            if (a % ATTR_HI_FIRST == 0) begin
               c0 = 1'b0;
               c1 = 1'b0;
            end
         end else if ({1'b0, a[6:0]} <= SOLID_LIMIT && {1'b0, a[6:0]} % ATTR_HI_FIRST == 0) begin
            c0 = 1'b0;
            c1 = 1'b0;
         end
      endfunction

      // Glyph after bold bank and font set under the current registers.
      function logic [GLYPH_W-1:0] glyph_of(input logic [CHAR_W-1:0] chr,
                                            input logic [ATTR_W-1:0] attr);
         bit c0;
         bit c1;
         bit bold;
         classify_attr(attr, c0, c1, bold);
         // Thin font swaps which bank the bold class reads
         return {font_options[1:0], font_options[2] == bold, chr};
      endfunction

      // Note one accepted command: store a font byte or queue the predicted slice.
      function void note_cmd(input cell_cmd_type c);
         bit c0;
         bit c1;
         bit bold;
         bit in_line;
         bit cursor;
         bit blinking;
         logic [GLYPH_W-1:0]     glyph;
         logic [FONT_DATA_W-1:0] row;
         slice_type s;
         if (c.command == CMD_LOAD) begin
            font_rows[c.font_address] = c.font_byte;
            loads_seen++;
            return;
         end
         in_line  = !cursor_off && cursor_start * 2 <= c.scanline &&
                    cursor_end * 2 >= c.scanline;
         cursor   = c.at_cursor && in_line && video_enable && c.blink_phase;
         blinking = c.blink_phase && blink_mode && c.attribute[7] && !cursor;
         classify_attr(c.attribute, c0, c1, bold);
         if (blinking) c1 = c0;
         glyph = glyph_of(c.char_code, c.attribute);
         row   = font_rows[{glyph, c.scanline}];
         s.pixels = (row & {PIXELS_W{c1}}) | (~row & {PIXELS_W{c0}});
         if (cursor) s.pixels = ~s.pixels;
         s.glyph_index = glyph;
         expected_slices.push_back(s);
         renders_seen++;
      endfunction

      // Compare one response transfer against the oldest predicted slice.
      function void check_slice(input logic [PIXELS_W-1:0] pixels,
                                input logic [GLYPH_W-1:0] glyph_index);
         slice_type s;
         if (expected_slices.size() == 0) begin
            $error("response with no render pending: pixels %02h glyph_index %03h",
                   pixels, glyph_index);
            failures++;
            return;
         end
         s = expected_slices.pop_front();
         slices_checked++;
         if (pixels !== s.pixels) begin
            $error("pixels mismatch: expected %02h, actual %02h", s.pixels, pixels);
            failures++;
         end
         if (glyph_index !== s.glyph_index) begin
            $error("glyph_index mismatch: expected %03h, actual %03h", s.glyph_index,
                   glyph_index);
            failures++;
         end
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ATTR_MAP:     attr_map     = data;
            CSR_CURSOR_START: cursor_start = data;
            CSR_CURSOR_END:   cursor_end   = data;
            CSR_CURSOR_OFF:   cursor_off   = data[0];
            CSR_BLINK_MODE:   blink_mode   = data[0];
            CSR_VIDEO_ENABLE: video_enable = data[0];
            CSR_FONT_OPTIONS: font_options = data[2:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_slices.size();
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic                   req_command      = CMD_RENDER;
   logic [FONT_ADDR_W-1:0] req_font_address = '0;
   logic [FONT_DATA_W-1:0] req_font_byte    = '0;
   logic [CHAR_W-1:0]      req_char_code    = '0;
   logic [ATTR_W-1:0]      req_attribute    = '0;
   logic [SCAN_W-1:0]      req_scanline     = '0;
   logic                   req_at_cursor    = 1'b0;
   logic                   req_blink_phase  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [PIXELS_W-1:0]    rsp_pixels;
   logic [GLYPH_W-1:0]     rsp_glyph_index;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index        = CSR_ATTR_MAP;
   logic [CSR_DATA_W-1:0]  csr_data         = '0;

   slice_scoreboard        sb;
   bit                     font_loaded [FONT_BYTES_DEFAULT];
   logic [CSR_DATA_W-1:0]  setting [NUM_REGS];
   bit                     no_idle      = 1'b0;
   bit                     hold_request = 1'b0;
   int                     items_sent   = 0;
   int                     cycle_count  = 0;

   text_cell_attribute_renderer dut (.*);

   always #5 clock = ~clock;

   // Observe transfers on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_cmd(cell_cmd_type'({req_command, req_font_address, req_font_byte,
                                        req_char_code, req_attribute, req_scanline,
                                        req_at_cursor, req_blink_phase}));
         if (rsp_valid && rsp_ready)
            sb.check_slice(rsp_pixels, rsp_glyph_index);
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_data);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic cell_cmd_type random_cmd(input logic command);
      cell_cmd_type c;
      c.command      = command;
      c.font_address = FONT_ADDR_W'($urandom);
      c.font_byte    = FONT_DATA_W'($urandom);
      c.char_code    = CHAR_W'($urandom);
      c.attribute    = ATTR_W'($urandom);
      c.scanline     = SCAN_W'($urandom);
      c.at_cursor    = 1'($urandom);
      c.blink_phase  = 1'($urandom);
      return c;
   endfunction

   // Attributes on the edges of the color classes
   function automatic logic [ATTR_W-1:0] key_attr();
      case ($urandom_range(0, 19))
         0:       return 8'h00;
         1:       return ATTR_LO_FIRST;
         2:       return ATTR_NORMAL;
         3:       return 8'h08;
         4:       return ATTR_LO_LAST;
         5:       return ATTR_NORMAL_BOLD;
         6:       return 8'h10;
         7:       return ATTR_HI_FIRST;
         8:       return 8'h77;
         9:       return 8'h78;
         10:      return 8'h80;
         11:      return ATTR_BLINK_FIRST;
         12:      return ATTR_BLINK_NORM;
         13:      return 8'h88;
         14:      return ATTR_BLINK_LAST;
         15:      return ATTR_BLINK_BOLD;
         16:      return 8'h90;
         17:      return 8'hF7;
         18:      return 8'hF8;
         default: return 8'hFF;
      endcase
   endfunction

   // Offer one transfer, hold it until taken, then idle for a random gap.
   task automatic send_cmd(input cell_cmd_type c);
      int gap;
      req_valid        <= 1'b1;
      req_command      <= c.command;
      req_font_address <= c.font_address;
      req_font_byte    <= c.font_byte;
      req_char_code    <= c.char_code;
      req_attribute    <= c.attribute;
      req_scanline     <= c.scanline;
      req_at_cursor    <= c.at_cursor;
      req_blink_phase  <= c.blink_phase;
      do @(posedge clock); while (!req_ready);
      if (c.command == CMD_LOAD) font_loaded[c.font_address] = 1'b1;
      items_sent++;
      gap = random_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Render a slice; load its font row first if it was never written.
   task automatic render_cell(input logic [CHAR_W-1:0] chr, input logic [ATTR_W-1:0] attr,
                              input logic [SCAN_W-1:0] line, input logic cur,
                              input logic phase);
      cell_cmd_type c;
      logic [FONT_ADDR_W-1:0] addr;
      addr = {sb.glyph_of(chr, attr), line};
      // Occasionally rewrite a loaded row too
      if (!font_loaded[addr] || $urandom_range(0, 9) == 0) begin
         c = random_cmd(CMD_LOAD);
         c.font_address = addr;
         send_cmd(c);
      end
      c = random_cmd(CMD_RENDER);
      c.char_code   = chr;
      c.attribute   = attr;
      c.scanline    = line;
      c.at_cursor   = cur;
      c.blink_phase = phase;
      send_cmd(c);
   endtask

   // Drop valid, wait for every predicted slice, then let trailing loads finish.
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting();
      write_reg(CSR_ATTR_MAP,     setting[CSR_ATTR_MAP]);
      write_reg(CSR_CURSOR_START, setting[CSR_CURSOR_START]);
      write_reg(CSR_CURSOR_END,   setting[CSR_CURSOR_END]);
      write_reg(CSR_CURSOR_OFF,   setting[CSR_CURSOR_OFF]);
      write_reg(CSR_BLINK_MODE,   setting[CSR_BLINK_MODE]);
      write_reg(CSR_VIDEO_ENABLE, setting[CSR_VIDEO_ENABLE]);
      write_reg(CSR_FONT_OPTIONS, setting[CSR_FONT_OPTIONS]);
      write_reg(CSR_UNUSED,       CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (int held = 0; held < LONG_HOLD; held++) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = random_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin
      cell_cmd_type c;
      int target;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: address extremes, top glyph, cursor rows and the attribute classes
      c = random_cmd(CMD_LOAD);
      c.font_address = '0;
      c.font_byte    = '0;
      send_cmd(c);
      c = random_cmd(CMD_LOAD);
      c.font_address = '1;
      c.font_byte    = '1;
      send_cmd(c);
      render_cell(8'hFF, ATTR_NORMAL_BOLD, 4'hF, 1'b0, 1'b0);
      render_cell(8'h00, 8'h00, 4'h0, 1'b0, 1'b1);
      render_cell(8'h41, ATTR_NORMAL, 4'hC, 1'b1, 1'b1);
      render_cell(8'h41, ATTR_NORMAL, 4'hF, 1'b1, 1'b1);
      render_cell(8'h42, 8'h70, 4'h5, 1'b0, 1'b0);
      render_cell(8'h43, ATTR_LO_FIRST, 4'h3, 1'b0, 1'b1);
      render_cell(8'h44, ATTR_BLINK_NORM, 4'h7, 1'b0, 1'b1);
      render_cell(8'h45, ATTR_BLINK_BOLD, 4'h8, 1'b0, 1'b0);
      render_cell(8'h46, ATTR_HI_FIRST, 4'h9, 1'b0, 1'b0);
      render_cell(8'h48, 8'hFF, 4'hE, 1'b1, 1'b1);
      settle(SETTLE_CYCLES);

      // Random traffic under a series of register settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         foreach (setting[i]) setting[i] = CSR_DATA_W'($urandom);
         case (p)
            // all registers at their lowest
            0: foreach (setting[i]) setting[i] = '0;
            // all registers at their highest, wide data masked down
            1: foreach (setting[i]) setting[i] = '1;
            // cursor over the whole cell with the blink table
            2: begin
               setting[CSR_CURSOR_START] = '0;
               setting[CSR_CURSOR_END]   = '1;
               setting[CSR_CURSOR_OFF]   = 4'hE;
               setting[CSR_BLINK_MODE]   = 4'h1;
               setting[CSR_VIDEO_ENABLE] = 4'h1;
            end
            default: ;
         endcase
         apply_setting();

         // One phase runs flat out while the response side holds off
         no_idle = (p == 3);
         if (p == 3) hold_request = 1'b1;

         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            if ($urandom_range(0, 99) < 15) begin
               send_cmd(random_cmd(CMD_LOAD));
            end else begin
               render_cell(($urandom_range(0, 1) != 0) ? CHAR_W'($urandom_range(32, 39))
                                                      : CHAR_W'($urandom),
                           ($urandom_range(0, 1) != 0) ? key_attr() : ATTR_W'($urandom),
                           SCAN_W'($urandom), 1'($urandom), 1'($urandom));
            end
         end
         no_idle = 1'b0;
         settle(SETTLE_CYCLES);
      end

      $display("Checked %0d slices from %0d renders, with %0d font loads in between,",
               sb.slices_checked, sb.renders_seen, sb.loads_seen);
      $display("under the reset setting and %0d written register settings.", NUM_PHASES);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
